// ===== sv/biquad_highpass_interleaved_defines.svh =====
// Assertion macros shared by the biquad high-pass filter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BIQUAD_HIGHPASS_INTERLEAVED_DEFINES_SVH
`define BIQUAD_HIGHPASS_INTERLEAVED_DEFINES_SVH

// Checked on every rising edge except while reset is held.
`define BQHP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BQHP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bqhp_pkg.sv =====
// Shared types and constants for the interleaved biquad high-pass filter.
// Depends on nothing; used by the interfaces, the datapath and the top level.
`timescale 1ns / 1ps

package bqhp_pkg;

  localparam int unsigned MAX_CHANNELS_DEF   = 2;
  localparam int unsigned COEF_FRAC_BITS_DEF = 28;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned COEF_W      = 32;
  localparam int unsigned ACC_W       = 40;
  localparam int unsigned Q_FRAC      = 16;
  localparam int unsigned COUNT_W     = 2;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic signed [COEF_W-1:0]   B0_RESET   = 32'sd268435456;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_B0       = 3'd0,
    REG_B1       = 3'd1,
    REG_B2       = 3'd2,
    REG_A1       = 3'd3,
    REG_A2       = 3'd4,
    REG_CHANNELS = 3'd5,
    REG_ENABLE   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_set_t;

  // Past inputs are whole samples; past outputs are Q.16 and unclamped.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [ACC_W-1:0]    y1;
    logic signed [ACC_W-1:0]    y2;
  } taps_t;

endpackage

// ===== sv/bqhp_in_if.sv =====
// Input sample channel: valid/ready handshake carrying one PCM sample request.
// Depends on bqhp_pkg for the sample width.
`timescale 1ns / 1ps

interface bqhp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bqhp_pkg::SAMPLE_W-1:0] sample_in;
  logic                                 buffer_start;

  modport source (output valid, output sample_in, output buffer_start, input ready);
  modport sink   (input valid, input sample_in, input buffer_start, output ready);
endinterface

// ===== sv/bqhp_out_if.sv =====
// Output sample channel: valid/ready handshake carrying one filtered sample request.
// Depends on bqhp_pkg for the sample width.
`timescale 1ns / 1ps

interface bqhp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bqhp_pkg::SAMPLE_W-1:0] sample_out;
  logic                                 channel_index;

  modport source (output valid, output sample_out, output channel_index, input ready);
  modport sink   (input valid, input sample_out, input channel_index, output ready);
endinterface

// ===== sv/bqhp_mac.sv =====
// Biquad arithmetic: five Q3.F by Q.16 products, their sum, 40-bit saturation
// and the clamped integer sample. Depends on bqhp_pkg.
`timescale 1ns / 1ps

module bqhp_mac #(
  parameter int unsigned COEF_FRAC_BITS = bqhp_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic signed [bqhp_pkg::SAMPLE_W-1:0] sample,
  input  bqhp_pkg::coef_set_t                  coefs,
  input  bqhp_pkg::taps_t                      taps,
  output logic signed [bqhp_pkg::ACC_W-1:0]    acc,
  output logic signed [bqhp_pkg::SAMPLE_W-1:0] result
);

  localparam int unsigned ACC_W   = bqhp_pkg::ACC_W;
  localparam int unsigned Q_FRAC  = bqhp_pkg::Q_FRAC;
  localparam int unsigned COEF_W  = bqhp_pkg::COEF_W;
  localparam int unsigned SMP_W   = bqhp_pkg::SAMPLE_W;
  localparam int unsigned HI_W    = COEF_W + ACC_W - Q_FRAC;
  localparam int unsigned LO_W    = COEF_W + Q_FRAC + 1;
  localparam int unsigned PROD_W  = COEF_W + ACC_W;
  localparam int unsigned SUM_W   = PROD_W + 3;
  localparam int unsigned WHOLE_W = ACC_W - Q_FRAC + 1;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

  // floor(coef * v / 2^frac), with the Q.16 operand split into an integer
  // part and an unsigned fraction so that no single product is too wide.
  function automatic logic signed [PROD_W-1:0] mul_q16(
    input logic signed [COEF_W-1:0] coef,
    input logic signed [ACC_W-1:0]  v,
    input int unsigned              frac
  );
    logic signed [ACC_W-Q_FRAC-1:0] vh;
    logic signed [Q_FRAC:0]         vl;
    logic signed [HI_W-1:0]         hi;
    logic signed [LO_W-1:0]         lo;
    logic signed [PROD_W-1:0]       full;
    vh   = v[ACC_W-1:Q_FRAC];
    vl   = {1'b0, v[Q_FRAC-1:0]};
    hi   = coef * vh;
    lo   = coef * vl;
    full = $signed({hi, {Q_FRAC{1'b0}}}) + PROD_W'(lo);
    return full >>> frac;
  endfunction

  logic signed [ACC_W-1:0]   xq;
  logic signed [ACC_W-1:0]   x1q;
  logic signed [ACC_W-1:0]   x2q;
  logic signed [SUM_W-1:0]   sum;
  logic signed [ACC_W:0]     biased;
  logic signed [WHOLE_W-1:0] whole;

  assign xq  = {{(ACC_W-SMP_W-Q_FRAC){sample[SMP_W-1]}}, sample, {Q_FRAC{1'b0}}};
  assign x1q = {{(ACC_W-SMP_W-Q_FRAC){taps.x1[SMP_W-1]}}, taps.x1, {Q_FRAC{1'b0}}};
  assign x2q = {{(ACC_W-SMP_W-Q_FRAC){taps.x2[SMP_W-1]}}, taps.x2, {Q_FRAC{1'b0}}};

  assign sum = SUM_W'(mul_q16(coefs.b0, xq, COEF_FRAC_BITS))
             + SUM_W'(mul_q16(coefs.b1, x1q, COEF_FRAC_BITS))
             + SUM_W'(mul_q16(coefs.b2, x2q, COEF_FRAC_BITS))
             - SUM_W'(mul_q16(coefs.a1, taps.y1, COEF_FRAC_BITS))
             - SUM_W'(mul_q16(coefs.a2, taps.y2, COEF_FRAC_BITS));

  always_comb begin
    if (sum > SAT_HI) begin
      acc = SAT_HI[ACC_W-1:0];
    end else if (sum < SAT_LO) begin
      acc = SAT_LO[ACC_W-1:0];
    end else begin
      acc = sum[ACC_W-1:0];
    end
  end

  // Adding an all-ones fraction before the arithmetic shift turns the floor
  // into a truncation toward zero for negative values.
  assign biased = $signed({acc[ACC_W-1], acc})
                + $signed({{(ACC_W+1-Q_FRAC){1'b0}}, {Q_FRAC{acc[ACC_W-1]}}});
  assign whole  = biased[ACC_W:Q_FRAC];

  always_comb begin
    if (whole > WHOLE_W'(bqhp_pkg::SAMPLE_MAX)) begin
      result = bqhp_pkg::SAMPLE_MAX;
    end else if (whole < WHOLE_W'(bqhp_pkg::SAMPLE_MIN)) begin
      result = bqhp_pkg::SAMPLE_MIN;
    end else begin
      result = whole[SMP_W-1:0];
    end
  end

endmodule

// ===== sv/biquad_highpass_interleaved.sv =====
// A sample request accepted into the input register moves to the result register
// when it advances, and leaves the block from there once the output is taken.
// Throughput: one sample per cycle while the output is not stalled; the filter feedback
// closes combinationally through the five multipliers into the per-channel output delays.
// Reset (synchronous, active high) loads the default coefficients (unity
// pass, filter off, one channel), clears all delay state and empties both stages.
`timescale 1ns / 1ps
`include "biquad_highpass_interleaved_defines.svh"

module biquad_highpass_interleaved #(
  parameter int unsigned MAX_CHANNELS   = bqhp_pkg::MAX_CHANNELS_DEF,
  parameter int unsigned COEF_FRAC_BITS = bqhp_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  bqhp_in_if.sink                                pcm,
  bqhp_out_if.source                             filtered,
  input  logic                                   wr_en,
  input  logic [bqhp_pkg::CFG_INDEX_W-1:0]       wr_index,
  input  logic [bqhp_pkg::CFG_DATA_W-1:0]        wr_data
);

  localparam int unsigned SLOT_CAP = (MAX_CHANNELS < 2) ? MAX_CHANNELS : 2;
  localparam int unsigned SMP_W    = bqhp_pkg::SAMPLE_W;
  localparam int unsigned ACC_W    = bqhp_pkg::ACC_W;
  localparam int unsigned COEF_W   = bqhp_pkg::COEF_W;

  // Configuration registers.
  bqhp_pkg::coef_set_t             coefs;
  logic [bqhp_pkg::COUNT_W-1:0]    chan_count;
  logic                            filter_en;

  // Per-channel delay lines and the interleave phase.
  logic signed [SMP_W-1:0] x1 [SLOT_CAP];
  logic signed [SMP_W-1:0] x2 [SLOT_CAP];
  logic signed [ACC_W-1:0] y1 [SLOT_CAP];
  logic signed [ACC_W-1:0] y2 [SLOT_CAP];
  logic                    phase;

  // Input register.
  logic                    s1_valid;
  logic signed [SMP_W-1:0] s1_sample;
  logic                    s1_start;

  // Result register.
  logic                    out_valid;
  logic signed [SMP_W-1:0] out_sample;
  logic                    out_chan;

  logic                    advance;
  logic                    two_slots;
  logic                    active;
  logic                    slot;
  bqhp_pkg::taps_t         taps;
  logic signed [ACC_W-1:0] acc;
  logic signed [SMP_W-1:0] filt_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0   <= bqhp_pkg::B0_RESET;
      coefs.b1   <= '0;
      coefs.b2   <= '0;
      coefs.a1   <= '0;
      coefs.a2   <= '0;
      chan_count <= bqhp_pkg::COUNT_W'(1);
      filter_en  <= 1'b0;
    end else if (wr_en) begin
      case (bqhp_pkg::cfg_reg_t'(wr_index))
        bqhp_pkg::REG_B0:       coefs.b0   <= wr_data[COEF_W-1:0];
        bqhp_pkg::REG_B1:       coefs.b1   <= wr_data[COEF_W-1:0];
        bqhp_pkg::REG_B2:       coefs.b2   <= wr_data[COEF_W-1:0];
        bqhp_pkg::REG_A1:       coefs.a1   <= wr_data[COEF_W-1:0];
        bqhp_pkg::REG_A2:       coefs.a2   <= wr_data[COEF_W-1:0];
        bqhp_pkg::REG_CHANNELS: chan_count <= wr_data[bqhp_pkg::COUNT_W-1:0];
        bqhp_pkg::REG_ENABLE:   filter_en  <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign advance      = s1_valid && (!out_valid || filtered.ready);
  assign pcm.ready    = !s1_valid || advance;

  // A count of three behaves as two; a count of zero leaves only slot 0.
  assign two_slots = (SLOT_CAP >= 2) && (chan_count >= 2'd2);
  assign active    = filter_en && (chan_count != '0);
  assign slot      = (two_slots && !s1_start) ? phase : 1'b0;

  // A buffer start sees cleared history for this sample.
  always_comb begin
    if (s1_start) begin
      taps = '0;
    end else begin
      taps.x1 = x1[slot];
      taps.x2 = x2[slot];
      taps.y1 = y1[slot];
      taps.y2 = y2[slot];
    end
  end

  bqhp_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .sample (s1_sample),
    .coefs  (coefs),
    .taps   (taps),
    .acc    (acc),
    .result (filt_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_CAP; i++) begin
        x1[i] <= '0;
        x2[i] <= '0;
        y1[i] <= '0;
        y2[i] <= '0;
      end
      phase <= 1'b0;
    end else if (advance) begin
      // The slot being filtered takes its new history; a buffer start clears the rest.
      for (int i = 0; i < SLOT_CAP; i++) begin
        if (active && (slot == 1'(i))) begin
          x1[i] <= s1_sample;
          x2[i] <= taps.x1;
          y1[i] <= acc;
          y2[i] <= taps.y1;
        end else if (s1_start) begin
          x1[i] <= '0;
          x2[i] <= '0;
          y1[i] <= '0;
          y2[i] <= '0;
        end
      end
      phase <= two_slots ? ~slot : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pcm.valid && pcm.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pcm.valid && pcm.ready) begin
      s1_sample <= pcm.sample_in;
      s1_start  <= pcm.buffer_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (filtered.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sample <= active ? filt_sample : s1_sample;
      out_chan   <= slot;
    end
  end

  assign filtered.valid         = out_valid;
  assign filtered.sample_out    = out_sample;
  assign filtered.channel_index = out_chan;

  `BQHP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && !s1_valid, "stages not empty after reset")
  `BQHP_ASSERT(a_hold_input, clk, rst, s1_valid && !advance |=> s1_valid && $stable(s1_sample), "input register lost a waiting request")
  `BQHP_ASSERT(a_bypass, clk, rst, advance && !active |=> out_sample == $past(s1_sample), "disabled filter altered the sample")
  `BQHP_ASSERT(a_start_phase, clk, rst, advance && s1_start && two_slots |=> phase, "buffer start did not restart the interleave at slot 0")
  `BQHP_ASSERT(a_single_slot, clk, rst, out_valid && !two_slots |-> !out_chan, "single-channel mode reported slot 1")

endmodule

// ===== verif/biquad_highpass_interleaved_test.sv =====
// Self-checking testbench for the interleaved biquad high-pass filter.
// Depends on bqhp_pkg, the bqhp_in_if and bqhp_out_if channels and the filter top level.
`timescale 1ns / 1ps

module biquad_highpass_interleaved_test;

  localparam int SETTLE_CYCLES = 3;
  localparam int LONG_HOLD     = 64;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int REPORT_LIMIT  = 10;
  localparam int TERM_W        = 51;

  localparam logic signed [TERM_W-1:0] ACC_HI = 51'sh7F_FFFF_FFFF;
  localparam logic signed [TERM_W-1:0] ACC_LO = -51'sh80_0000_0000;
  localparam logic signed [TERM_W-1:0] OUT_HI = 51'sd32767;
  localparam logic signed [TERM_W-1:0] OUT_LO = -51'sd32768;

  typedef enum logic [2:0] {OP_SAMPLE, OP_WRITE, OP_DRAIN, OP_PACE, OP_HOLD} plan_kind_t;

  typedef struct {
    plan_kind_t                           kind;
    logic signed [bqhp_pkg::SAMPLE_W-1:0] sample;
    logic                                 start;
    bqhp_pkg::cfg_reg_t                   index;
    logic [bqhp_pkg::CFG_DATA_W-1:0]      data;
  } plan_entry_t;

  typedef struct packed {
    logic signed [bqhp_pkg::SAMPLE_W-1:0] sample;
    logic                                 channel;
  } pcm_result_t;

  logic                             clk      = 1'b0;
  logic                             rst;
  logic                             wr_en    = 1'b0;
  logic [bqhp_pkg::CFG_INDEX_W-1:0] wr_index = '0;
  logic [bqhp_pkg::CFG_DATA_W-1:0]  wr_data  = '0;

  bqhp_in_if  pcm_ch ();
  bqhp_out_if filt_ch ();

  biquad_highpass_interleaved dut (
    .clk      (clk),
    .rst      (rst),
    .pcm      (pcm_ch),
    .filtered (filt_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  plan_entry_t plan_q[$];
  pcm_result_t expected_pcm[$];

  // Predicted filter state and register contents.
  bqhp_pkg::coef_set_t          coefs;
  logic [bqhp_pkg::COUNT_W-1:0] chan_count;
  logic                         filter_on;
  bqhp_pkg::taps_t              taps[bqhp_pkg::MAX_CHANNELS_DEF];
  logic                         phase;

  logic pace;
  int   hold_token;
  int   issued          = 0;
  int   results_checked = 0;
  int   results_seen    = 0;
  int   failures        = 0;
  int   send_gap, quiet_cycles, recv_gap, hold_left, holds_served, idle_edges;
  int   filtered_count  = 0;
  int   passed_count    = 0;
  int   start_count     = 0;
  int   write_count     = 0;
  int   sat_count       = 0;
  int   clamp_count     = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int idle_gap();
    int roll;
    if (!pace) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [bqhp_pkg::ACC_W-1:0] to_q16(
    logic signed [bqhp_pkg::SAMPLE_W-1:0] x
  );
    return {{(bqhp_pkg::ACC_W-bqhp_pkg::SAMPLE_W-bqhp_pkg::Q_FRAC){x[bqhp_pkg::SAMPLE_W-1]}},
            x, {bqhp_pkg::Q_FRAC{1'b0}}};
  endfunction

  // Floor of coef * value / 2^frac, kept exact at full product width.
  function automatic logic signed [TERM_W-1:0] coef_term(
    logic signed [bqhp_pkg::COEF_W-1:0] coef,
    logic signed [bqhp_pkg::ACC_W-1:0]  value
  );
    logic signed [71:0] wide_coef;
    logic signed [71:0] wide_value;
    logic signed [71:0] product;
    wide_coef  = coef;
    wide_value = value;
    product    = (wide_coef * wide_value) >>> bqhp_pkg::COEF_FRAC_BITS_DEF;
    return product[TERM_W-1:0];
  endfunction

  function automatic void filter_sample(logic signed [bqhp_pkg::SAMPLE_W-1:0] x, logic start);
    logic [bqhp_pkg::COUNT_W-1:0] slots;
    logic                         slot;
    logic signed [TERM_W-1:0]     acc;
    logic signed [TERM_W-1:0]     whole;
    pcm_result_t                  res;
    slots = (chan_count > 2'd2) ? 2'd2 : chan_count;
    if (start) begin
      foreach (taps[i]) taps[i] = '0;
      phase = 1'b0;
      start_count++;
    end
    slot        = (slots >= 2'd2) ? phase : 1'b0;
    res.sample  = x;
    res.channel = slot;
    if (filter_on && slots != 2'd0) begin
      acc = coef_term(coefs.b0, to_q16(x))
          + coef_term(coefs.b1, to_q16(taps[slot].x1))
          + coef_term(coefs.b2, to_q16(taps[slot].x2))
          - coef_term(coefs.a1, taps[slot].y1)
          - coef_term(coefs.a2, taps[slot].y2);
      if (acc > ACC_HI) begin
        acc = ACC_HI;
        sat_count++;
      end else if (acc < ACC_LO) begin
        acc = ACC_LO;
        sat_count++;
      end
      taps[slot].x2 = taps[slot].x1;
      taps[slot].x1 = x;
      taps[slot].y2 = taps[slot].y1;
      taps[slot].y1 = acc[bqhp_pkg::ACC_W-1:0];
      // The integer part is cut toward zero, so negative sums are handled by magnitude.
      whole = (acc < 0) ? -((-acc) >>> bqhp_pkg::Q_FRAC) : (acc >>> bqhp_pkg::Q_FRAC);
      if (whole > OUT_HI) begin
        res.sample = bqhp_pkg::SAMPLE_MAX;
        clamp_count++;
      end else if (whole < OUT_LO) begin
        res.sample = bqhp_pkg::SAMPLE_MIN;
        clamp_count++;
      end else begin
        res.sample = whole[bqhp_pkg::SAMPLE_W-1:0];
      end
      filtered_count++;
    end else begin
      passed_count++;
    end
    phase = (slots >= 2'd2) ? ~slot : 1'b0;
    expected_pcm.push_back(res);
    issued++;
  endfunction

  function automatic void apply_write(bqhp_pkg::cfg_reg_t index,
                                      logic [bqhp_pkg::CFG_DATA_W-1:0] data);
    case (index)
      bqhp_pkg::REG_B0:       coefs.b0   = data;
      bqhp_pkg::REG_B1:       coefs.b1   = data;
      bqhp_pkg::REG_B2:       coefs.b2   = data;
      bqhp_pkg::REG_A1:       coefs.a1   = data;
      bqhp_pkg::REG_A2:       coefs.a2   = data;
      bqhp_pkg::REG_CHANNELS: chan_count = data[bqhp_pkg::COUNT_W-1:0];
      bqhp_pkg::REG_ENABLE:   filter_on  = data[0];
      default: ;
    endcase
    write_count++;
  endfunction

  task automatic plan_sample(logic signed [bqhp_pkg::SAMPLE_W-1:0] x, logic start);
    plan_entry_t entry;
    entry.kind   = OP_SAMPLE;
    entry.sample = x;
    entry.start  = start;
    entry.index  = bqhp_pkg::REG_B0;
    entry.data   = '0;
    plan_q.push_back(entry);
  endtask

  task automatic plan_control(plan_kind_t kind, bqhp_pkg::cfg_reg_t index,
                              logic [bqhp_pkg::CFG_DATA_W-1:0] data);
    plan_entry_t entry;
    entry.kind   = kind;
    entry.sample = '0;
    entry.start  = 1'b0;
    entry.index  = index;
    entry.data   = data;
    plan_q.push_back(entry);
  endtask

  task automatic configure(int b0, int b1, int b2, int a1, int a2, int count, bit enable);
    int vals[7];
    vals = '{b0, b1, b2, a1, a2, count, int'(enable)};
    for (int i = 0; i < 7; i++) plan_control(OP_WRITE, bqhp_pkg::cfg_reg_t'(i), vals[i]);
  endtask

  // Sender: takes the plan in order; register writes and drain points wait for an empty pipeline.
  always @(posedge clk) begin
    plan_entry_t entry;
    logic        offer;
    logic        write_now;
    if (rst) begin
      pcm_ch.valid        <= 1'b0;
      pcm_ch.sample_in    <= '0;
      pcm_ch.buffer_start <= 1'b0;
      wr_en               <= 1'b0;
      wr_index            <= '0;
      wr_data             <= '0;
      pace                <= 1'b1;
      hold_token          <= 0;
      coefs               = '0;
      coefs.b0            = bqhp_pkg::B0_RESET;
      chan_count          = 2'd1;
      filter_on           = 1'b0;
      foreach (taps[i]) taps[i] = '0;
      phase               = 1'b0;
      send_gap            = 0;
      quiet_cycles        = 0;
    end else begin
      offer     = pcm_ch.valid;
      write_now = 1'b0;
      if (pcm_ch.valid && pcm_ch.ready) begin
        filter_sample(pcm_ch.sample_in, pcm_ch.buffer_start);
        offer = 1'b0;
      end
      if (!offer && issued == results_checked) quiet_cycles++;
      else quiet_cycles = 0;
      if (!offer && plan_q.size() > 0) begin
        entry = plan_q[0];
        case (entry.kind)
          OP_SAMPLE: begin
            if (send_gap > 0) begin
              send_gap--;
            end else begin
              pcm_ch.sample_in    <= entry.sample;
              pcm_ch.buffer_start <= entry.start;
              offer               = 1'b1;
              send_gap            = idle_gap();
              plan_q.delete(0);
            end
          end
          OP_WRITE: begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              wr_index  <= entry.index;
              wr_data   <= entry.data;
              write_now = 1'b1;
              apply_write(entry.index, entry.data);
              plan_q.delete(0);
            end
          end
          OP_DRAIN: begin
            if (quiet_cycles >= SETTLE_CYCLES) plan_q.delete(0);
          end
          OP_PACE: begin
            pace <= entry.data[0];
            plan_q.delete(0);
          end
          OP_HOLD: begin
            hold_token <= hold_token + 1;
            plan_q.delete(0);
          end
          default: plan_q.delete(0);
        endcase
      end
      pcm_ch.valid <= offer;
      wr_en        <= write_now;
    end
  end

  // Receiver: checks each result against the oldest prediction and stalls at random.
  always @(posedge clk) begin
    pcm_result_t want;
    if (rst) begin
      filt_ch.ready   <= 1'b0;
      results_checked <= 0;
      recv_gap        = 0;
      hold_left       = 0;
      holds_served    = 0;
    end else begin
      if (filt_ch.valid && filt_ch.ready) begin
        if (expected_pcm.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("unexpected result: sample %0d channel %0d",
                     filt_ch.sample_out, filt_ch.channel_index);
        end else begin
          want = expected_pcm.pop_front();
          results_seen++;
          results_checked <= results_seen;
          if (filt_ch.sample_out !== want.sample || filt_ch.channel_index !== want.channel) begin
            failures++;
            if (failures <= REPORT_LIMIT)
              $display("result %0d: expected sample %0d channel %0d, got sample %0d channel %0d",
                       results_seen, want.sample, want.channel,
                       filt_ch.sample_out, filt_ch.channel_index);
          end
        end
        recv_gap = idle_gap();
      end
      // A long hold-off lets the pipeline fill so that the input request stalls.
      if (hold_token != holds_served) begin
        holds_served = hold_token;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        filt_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        filt_ch.ready <= 1'b0;
      end else begin
        filt_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pcm_ch.valid && pcm_ch.ready) || (filt_ch.valid && filt_ch.ready) || wr_en)
      idle_edges = 0;
    else
      idle_edges++;
    if (idle_edges >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("biquad_highpass_interleaved_test NOT OK");
      $finish;
    end
  end

  initial begin
    int                                   random_items;
    int                                   phase_no;
    int                                   phase_len;
    int                                   style;
    int                                   roll;
    int                                   count;
    int                                   b[5];
    int                                   corner[5];
    real                                  w0;
    real                                  alpha;
    real                                  a0;
    logic signed [bqhp_pkg::SAMPLE_W-1:0] x;
    logic                                 start;

    rst                 = 1'b1;
    corner              = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 268435456, -268435456};

    // Reset defaults leave the filter off, so these pass straight through.
    plan_sample(bqhp_pkg::SAMPLE_MAX, 1'b1);
    plan_sample(bqhp_pkg::SAMPLE_MIN, 1'b0);
    plan_sample(16'sd0, 1'b0);
    plan_sample(-16'sd1, 1'b0);

    // Two interleaved channels with a mid-stream buffer start.
    configure(268435456, -536870912, 268435456, -520093696, 234881024, 2, 1'b1);
    plan_sample(bqhp_pkg::SAMPLE_MAX, 1'b1);
    plan_sample(bqhp_pkg::SAMPLE_MIN, 1'b0);
    plan_sample(bqhp_pkg::SAMPLE_MAX, 1'b0);
    plan_sample(bqhp_pkg::SAMPLE_MIN, 1'b0);
    plan_sample(16'sd1000, 1'b0);
    plan_sample(-16'sd1000, 1'b0);
    plan_sample(bqhp_pkg::SAMPLE_MAX, 1'b1);
    plan_sample(16'sd5, 1'b0);

    // Extreme coefficients drive the accumulator into saturation and the output into clamping.
    configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              1, 1'b1);
    plan_sample(bqhp_pkg::SAMPLE_MAX, 1'b1);
    repeat (3) plan_sample(bqhp_pkg::SAMPLE_MAX, 1'b0);
    repeat (3) plan_sample(bqhp_pkg::SAMPLE_MIN, 1'b0);

    // A channel count of zero passes through; three behaves as two.
    configure(bqhp_pkg::B0_RESET, 0, 0, 0, 0, 0, 1'b1);
    plan_sample(16'sd1234, 1'b0);
    plan_sample(-16'sd4321, 1'b0);
    configure(bqhp_pkg::B0_RESET, 0, 0, 0, 0, 3, 1'b1);
    plan_sample(16'sd100, 1'b1);
    plan_sample(-16'sd100, 1'b0);
    plan_sample(16'sd7, 1'b0);
    configure(bqhp_pkg::B0_RESET, 0, 0, 0, 0, 2, 1'b0);
    plan_sample(16'sd300, 1'b0);
    plan_sample(-16'sd300, 1'b0);

    random_items = 0;
    phase_no     = 0;
    while (random_items < RANDOM_ITEMS) begin
      style = $urandom_range(0, 9);
      if (style < 5) begin
        // A proper Butterworth high-pass at a random normalised cut-off.
        w0    = 2.0 * 3.14159265358979 * (0.002 + 0.45 * $urandom_range(0, 10000) / 10000.0);
        alpha = $sin(w0) * 0.7071067811865476;
        a0    = 1.0 + alpha;
        b[0]  = $rtoi((1.0 + $cos(w0)) / 2.0 / a0 * 268435456.0);
        b[1]  = $rtoi(-(1.0 + $cos(w0)) / a0 * 268435456.0);
        b[2]  = b[0];
        b[3]  = $rtoi(-2.0 * $cos(w0) / a0 * 268435456.0);
        b[4]  = $rtoi((1.0 - alpha) / a0 * 268435456.0);
      end else if (style < 7) begin
        foreach (b[i]) b[i] = int'($urandom_range(0, 536870912)) - 268435456;
      end else if (style < 9) begin
        foreach (b[i]) b[i] = $urandom();
      end else begin
        foreach (b[i]) b[i] = corner[$urandom_range(0, 4)];
      end
      roll  = $urandom_range(0, 9);
      count = (roll == 0) ? 0 : (roll == 1) ? 3 : (roll < 5) ? 1 : 2;
      configure(b[0], b[1], b[2], b[3], b[4], count, $urandom_range(0, 9) != 0);
      plan_control(OP_PACE, bqhp_pkg::REG_B0, (phase_no % 4 != 3) ? 1 : 0);
      phase_len = $urandom_range(60, 160);
      for (int k = 0; k < phase_len; k++) begin
        roll = $urandom_range(0, 9);
        if (roll < 7) x = 16'($urandom());
        else if (roll < 9) x = (roll == 7) ? bqhp_pkg::SAMPLE_MAX : bqhp_pkg::SAMPLE_MIN;
        else x = 16'($urandom_range(0, 512) - 256);
        start = (k == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 49) == 0;
        plan_sample(x, start);
        if ((phase_no == 2 || phase_no == 7) && k == 30)
          plan_control(OP_HOLD, bqhp_pkg::REG_B0, '0);
        if (phase_no == 5 && k == phase_len / 2)
          plan_control(OP_DRAIN, bqhp_pkg::REG_B0, '0);
      end
      random_items += phase_len;
      phase_no++;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (plan_q.size() != 0 || pcm_ch.valid || issued != results_checked);
    repeat (8) @(posedge clk);

    $display("Sent %0d samples under %0d register writes: %0d filtered, %0d passed through,",
             issued, write_count, filtered_count, passed_count);
    $display("%0d buffer starts; accumulator saturated %0d times, output clamped %0d times, %0d failures.",
             start_count, sat_count, clamp_count, failures + expected_pcm.size());
    if (failures == 0 && expected_pcm.size() == 0) begin
      $display("biquad_highpass_interleaved_test OK");
    end else begin
      $display("biquad_highpass_interleaved_test NOT OK");
    end
    $finish;
  end

endmodule
